@@ rtl/saw_pkg.sv @@
// Shared types and codes for the stop-and-wait echo-acknowledge sender.
// Used by saw_front, saw_fifo, saw_back and the top level; depends on nothing.
package saw_pkg;

  // Mode codes on the input channel.
  localparam logic [1:0] MODE_RX   = 2'd0;
  localparam logic [1:0] MODE_ENQ  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Codes on the send_kind output field.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_ATOM = 2'd1;
  localparam logic [1:0] SEND_INIT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_INIT_CHAR  = 1'b0;
  localparam logic CFG_ERROR_CHAR = 1'b1;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 9;

  // Classified operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_RX_INIT,
    OP_RX_DATA,
    OP_ENQ,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [7:0]        rx_byte;
    logic [WORD_W-1:0] message;
  } op_t;

  // One result word.
  typedef struct packed {
    logic [1:0]         send_kind;
    logic [WORD_W-1:0]  atom;
    logic               acked;
    logic               enqueue_accepted;
    logic [COUNT_W-1:0] queue_count;
    logic               link_ready;
  } res_t;

endpackage

@@ rtl/saw_front.sv @@
// Front end: accepts input words and classifies them into operations.
// Depends on saw_pkg; feeds saw_fifo.
module saw_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      mode,
  input  logic [7:0]      rx_byte,
  input  logic [63:0]     message,
  input  logic [7:0]      init_char,
  input  logic            fifo_full,
  output logic            push,
  output saw_pkg::op_t    push_op
);
  import saw_pkg::*;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    push_op.rx_byte = rx_byte;
    push_op.message = message;
    case (mode)
      MODE_RX:   push_op.kind = (rx_byte == init_char) ? OP_RX_INIT : OP_RX_DATA;
      MODE_ENQ:  push_op.kind = OP_ENQ;
      MODE_TICK: push_op.kind = OP_TICK;
      default:   push_op.kind = OP_NOP;
    endcase
  end

endmodule

@@ rtl/saw_fifo.sv @@
// Two-entry queue of classified operations between the front and the back.
// Depends on saw_pkg.
module saw_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  saw_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output saw_pkg::op_t pop_op
);
  import saw_pkg::*;

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign pop_op = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

endmodule

@@ rtl/saw_back.sv @@
// Back end: message queue, reply collection and compare, send decisions,
// and the output register. Depends on saw_pkg; fed by saw_fifo.
module saw_back #(
  parameter int MSG_BYTES   = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    error_char,
  input  logic          op_valid,
  input  saw_pkg::op_t  op,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output saw_pkg::res_t out_res
);
  import saw_pkg::*;

  localparam int MSG_W = 8 * MSG_BYTES;
  localparam int RC_W  = $clog2(MSG_BYTES + 1);
  localparam int BI_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TL_W  = CNT_W + 1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Queue storage; head and second entries are also kept in registers so
  // that a dequeue can send the new head in the same step.
  logic [MSG_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [MSG_W-1:0] mem_q;
  logic [MSG_W-1:0] head_data;
  logic [MSG_W-1:0] second_data;
  logic             rd_pend;
  logic [PTR_W-1:0] head_ptr;
  logic [CNT_W-1:0] fill;

  logic [7:0]       reply_buf [MSG_BYTES];
  logic [RC_W-1:0]  reply_count;
  logic             ack_seen;
  logic             link_up;

  logic             go;
  logic [MSG_W-1:0] msg;
  logic [MSG_W-1:0] reply_vec;
  logic             match;
  logic [TL_W-1:0]  tail_sum;
  logic [TL_W-1:0]  tail_wrap;
  logic [PTR_W-1:0] tail_idx;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_issue;

  logic             enq;
  logic             deq;
  logic             buf_we;
  logic             link_up_next;
  logic             ack_seen_next;
  logic [CNT_W-1:0] fill_next;
  logic [PTR_W-1:0] head_ptr_next;
  logic [RC_W-1:0]  reply_count_next;
  res_t             res;

  assign go  = op_valid && (!out_valid || !out_stall);
  assign pop = go;
  assign msg = op.message[MSG_W-1:0];

  // The last reply byte is the one arriving now; earlier ones sit in the buffer.
  for (genvar j = 0; j < MSG_BYTES; j++) begin : g_reply
    if (j < MSG_BYTES - 1) begin : g_buf
      assign reply_vec[8*j +: 8] = reply_buf[j+1];
    end else begin : g_last
      assign reply_vec[8*j +: 8] = op.rx_byte;
    end
  end

  assign match = (fill != '0) && (reply_buf[0] != error_char) && (reply_vec == head_data);

  assign tail_sum  = TL_W'(head_ptr) + TL_W'(fill);
  assign tail_wrap = (tail_sum >= TL_W'(QUEUE_DEPTH)) ? tail_sum - TL_W'(QUEUE_DEPTH)
                                                      : tail_sum;
  assign tail_idx  = tail_wrap[PTR_W-1:0];
  assign rd_addr   = ptr_inc(ptr_inc(head_ptr));
  assign rd_issue  = go && deq && (int'(fill) >= 3);

  always_comb begin
    enq              = 1'b0;
    deq              = 1'b0;
    buf_we           = 1'b0;
    link_up_next     = link_up;
    ack_seen_next    = ack_seen;
    fill_next        = fill;
    head_ptr_next    = head_ptr;
    reply_count_next = reply_count;
    res.send_kind        = SEND_NONE;
    res.atom             = '0;
    res.acked            = 1'b0;
    res.enqueue_accepted = 1'b0;
    case (op.kind)
      OP_RX_INIT: begin
        if (!link_up) begin
          link_up_next  = 1'b1;
          ack_seen_next = 1'b1;
        end
        res.send_kind = SEND_INIT;
      end
      OP_RX_DATA: begin
        if (link_up) begin
          if (reply_count == RC_W'(MSG_BYTES)) begin
            reply_count_next = '0;
            if (match) begin
              deq           = 1'b1;
              fill_next     = fill - CNT_W'(1);
              head_ptr_next = ptr_inc(head_ptr);
              ack_seen_next = 1'b1;
              res.acked     = 1'b1;
              if (fill != CNT_W'(1)) begin
                res.send_kind = SEND_ATOM;
                res.atom      = WORD_W'(second_data);
                ack_seen_next = 1'b0;
              end
            end else if (fill != '0) begin
              res.send_kind = SEND_ATOM;
              res.atom      = WORD_W'(head_data);
              ack_seen_next = 1'b0;
            end
          end else begin
            buf_we           = 1'b1;
            reply_count_next = reply_count + RC_W'(1);
          end
        end
      end
      OP_ENQ: begin
        if (fill < CNT_W'(QUEUE_DEPTH)) begin
          enq                  = 1'b1;
          fill_next            = fill + CNT_W'(1);
          res.enqueue_accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (link_up && ack_seen && (fill != '0)) begin
          res.send_kind = SEND_ATOM;
          res.atom      = WORD_W'(head_data);
          ack_seen_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.queue_count = COUNT_W'(fill_next);
    res.link_ready  = link_up_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr    <= '0;
      fill        <= '0;
      reply_count <= '0;
      ack_seen    <= 1'b0;
      link_up     <= 1'b0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (go) begin
        head_ptr    <= head_ptr_next;
        fill        <= fill_next;
        reply_count <= reply_count_next;
        ack_seen    <= ack_seen_next;
        link_up     <= link_up_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res <= res;
    end
    if (go && enq && (fill == '0)) begin
      head_data <= msg;
    end else if (go && deq) begin
      head_data <= second_data;
    end
    if (go && enq && (fill == CNT_W'(1))) begin
      second_data <= msg;
    end else if (rd_pend) begin
      second_data <= mem_q;
    end
    if (go && buf_we) begin
      reply_buf[reply_count[BI_W-1:0]] <= op.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (go && enq) begin
      queue_mem[tail_idx] <= msg;
    end
    if (rd_issue) begin
      mem_q <= queue_mem[rd_addr];
    end
  end

  // The refill of the second entry must land before another dequeue.
  a_refill_before_deq: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !(go && deq))
    else $error("dequeue while second entry refill is pending");

  a_atom_needs_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.send_kind == SEND_ATOM)) |-> out_res.link_ready)
    else $error("message sent before link is up");

  a_ack_needs_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.acked) |-> out_res.link_ready)
    else $error("acknowledge seen before link is up");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (go && deq) |=> (fill == $past(fill) - CNT_W'(1)))
    else $error("queue fill not reduced by dequeue");

endmodule

@@ rtl/stop_and_wait_echo_ack_sender_core.sv @@
// Stop-and-wait sender with echo acknowledgement: one result word per input word.
// A word passes through the two-entry queue, and its result is registered in the back end.
// Throughput: one word per cycle while out_stall is low, set by the back end step
// and the registered result; a two-entry queue decouples input from output stalls.
// Reset (synchronous, active high) empties the queue, drops the link and
// clears both configuration registers; message storage is not cleared.
module stop_and_wait_echo_ack_sender_core #(
  parameter int MSG_BYTES   = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [63:0] message,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  send_kind,
  output logic [63:0] atom,
  output logic        acked,
  output logic        enqueue_accepted,
  output logic [8:0]  queue_count,
  output logic        link_ready,
  // Configuration write port.
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import saw_pkg::*;

  // Configuration registers. The user must write them only while the block is
  // idle, which the block does not enforce; the front and back use them directly.
  logic [7:0] init_char;
  logic [7:0] error_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_char  <= 8'd0;
      error_char <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INIT_CHAR:  init_char  <= cfg_data;
        CFG_ERROR_CHAR: error_char <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic fifo_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic op_valid;
  op_t  op;
  res_t out_res;

  // The front classifies each accepted word: a received byte becomes either
  // an init character or a reply byte, based on the configured init char.
  saw_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .rx_byte   (rx_byte),
    .message   (message),
    .init_char (init_char),
    .fifo_full (fifo_full),
    .push      (push),
    .push_op   (push_op)
  );

  // The short queue lets the input keep flowing while a result word waits.
  saw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (fifo_full),
    .pop      (pop),
    .valid    (op_valid),
    .pop_op   (op)
  );

  // The back owns the message queue, the reply buffer and the link state,
  // and produces exactly one result word per operation.
  saw_back #(
    .MSG_BYTES   (MSG_BYTES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .error_char (error_char),
    .op_valid   (op_valid),
    .op         (op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign send_kind        = out_res.send_kind;
  assign atom             = out_res.atom;
  assign acked            = out_res.acked;
  assign enqueue_accepted = out_res.enqueue_accepted;
  assign queue_count      = out_res.queue_count;
  assign link_ready       = out_res.link_ready;

endmodule

@@ bench/saw_result_checker.sv @@
// Result checker for the stop-and-wait echo-acknowledge sender core.
// Watches the input, output and register ports, predicts every result word and
// compares it field by field. Depends on saw_pkg.
module saw_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [63:0] message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  send_kind,
  input  logic [63:0] atom,
  input  logic        acked,
  input  logic        enqueue_accepted,
  input  logic [8:0]  queue_count,
  input  logic        link_ready,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          results_due
);
  import saw_pkg::*;

  localparam int QUEUE_SLOTS = 8;
  localparam int REPLY_LEN   = 9;
  localparam int MAX_PRINTS  = 40;

  logic [63:0] msg_slots [QUEUE_SLOTS];
  logic [7:0]  reply_bytes [REPLY_LEN];
  int          slot_head;
  int          slot_fill;
  int          reply_len;
  bit          ack_ok;
  bit          link_on;
  logic [7:0]  init_code;
  logic [7:0]  error_code;
  res_t        due_results [$];
  res_t        want;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch on %s: got %0h, expected %0h", what, seen, wanted);
    end
    mismatches++;
  endtask

  // One step of the sender: updates the predicted state and returns the word
  // the block should produce for this input word.
  function automatic res_t step_sender(input logic [1:0] m, input logic [7:0] rx,
                                       input logic [63:0] msg);
    res_t r;
    bit   hit;
    int   slot;
    r = '0;
    case (m)
      MODE_RX: begin
        if (!link_on) begin
          if (rx == init_code) begin
            link_on     = 1'b1;
            ack_ok      = 1'b1;
            r.send_kind = SEND_INIT;
          end
        end else if (rx == init_code) begin
          r.send_kind = SEND_INIT;
        end else begin
          reply_bytes[reply_len] = rx;
          reply_len++;
          if (reply_len == REPLY_LEN) begin
            hit = (slot_fill != 0) && (reply_bytes[0] != error_code);
            if (hit) begin
              for (int i = 1; i < REPLY_LEN; i++) begin
                if (reply_bytes[i] != msg_slots[slot_head][8*(i-1) +: 8]) hit = 1'b0;
              end
            end
            if (hit) begin
              slot_head = (slot_head + 1) % QUEUE_SLOTS;
              slot_fill--;
              ack_ok  = 1'b1;
              r.acked = 1'b1;
            end
            // The new head, if any, goes out again whatever the reply said.
            if (slot_fill != 0) begin
              r.send_kind = SEND_ATOM;
              r.atom      = msg_slots[slot_head];
              ack_ok      = 1'b0;
            end
            reply_len = 0;
          end
        end
      end
      MODE_ENQ: begin
        if (slot_fill < QUEUE_SLOTS) begin
          slot            = (slot_head + slot_fill) % QUEUE_SLOTS;
          msg_slots[slot] = msg;
          slot_fill++;
          r.enqueue_accepted = 1'b1;
        end
      end
      MODE_TICK: begin
        if (link_on && ack_ok && slot_fill != 0) begin
          r.send_kind = SEND_ATOM;
          r.atom      = msg_slots[slot_head];
          ack_ok      = 1'b0;
        end
      end
      default: ;
    endcase
    r.queue_count = 9'(slot_fill);
    r.link_ready  = link_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      slot_head  = 0;
      slot_fill  = 0;
      reply_len  = 0;
      ack_ok     = 1'b0;
      link_on    = 1'b0;
      init_code  = 8'h00;
      error_code = 8'h00;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_INIT_CHAR:  init_code  = cfg_data;
          CFG_ERROR_CHAR: error_code = cfg_data;
          default: ;
        endcase
      end
      // The output word taken at this edge belongs to an earlier input word,
      // so it is matched before this edge's input word is predicted.
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with none pending", 64'd0, 64'd0);
        end else begin
          want = due_results.pop_front();
          if (send_kind !== want.send_kind)
            report_mismatch("send_kind", 64'(send_kind), 64'(want.send_kind));
          if (atom !== want.atom)
            report_mismatch("atom", atom, want.atom);
          if (acked !== want.acked)
            report_mismatch("acked", 64'(acked), 64'(want.acked));
          if (enqueue_accepted !== want.enqueue_accepted)
            report_mismatch("enqueue_accepted", 64'(enqueue_accepted),
                            64'(want.enqueue_accepted));
          if (queue_count !== want.queue_count)
            report_mismatch("queue_count", 64'(queue_count), 64'(want.queue_count));
          if (link_ready !== want.link_ready)
            report_mismatch("link_ready", 64'(link_ready), 64'(want.link_ready));
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(step_sender(mode, rx_byte, message));
      end
    end
    results_due <= due_results.size();
  end

endmodule

@@ bench/tb_stop_and_wait_echo_ack_sender_core.sv @@
// Top of the testbench for the stop-and-wait echo-acknowledge sender core.
// Generates words, stalls and register writes and gives the verdict; the
// prediction lives in saw_result_checker. Depends on saw_pkg and the core.
module tb_stop_and_wait_echo_ack_sender_core;
  import saw_pkg::*;

  // The fourth mode code has no meaning; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUEUE_SLOTS = 8;
  localparam int REPLY_LEN   = 9;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_WORDS = 70;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [63:0] message;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  send_kind;
  logic [63:0] atom;
  logic        acked;
  logic        enqueue_accepted;
  logic [8:0]  queue_count;
  logic        link_ready;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int results_due;
  int cycle_count;

  // Stimulus bookkeeping. The messages the block should still hold are kept
  // here only so that well-formed replies can echo the head message; the
  // checker does all the predicting.
  logic [63:0] held_msgs [$];
  logic [7:0]  init_now;
  logic [7:0]  err_now;
  bit          link_seen;
  int          reply_fill;
  bit          calm;
  bit          hold_go;
  int          words_sent;
  int          good_replies;
  int          bad_replies;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stop_and_wait_echo_ack_sender_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .rx_byte(rx_byte), .message(message),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_kind(send_kind), .atom(atom), .acked(acked),
    .enqueue_accepted(enqueue_accepted), .queue_count(queue_count),
    .link_ready(link_ready),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  saw_result_checker result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .rx_byte(rx_byte), .message(message),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_kind(send_kind), .atom(atom), .acked(acked),
    .enqueue_accepted(enqueue_accepted), .queue_count(queue_count),
    .link_ready(link_ready),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .results_due(results_due)
  );

  // Watchdog: a run that hangs anywhere ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver side. Normally it stalls in short random bursts; once, when the
  // stimulus asks for it, it holds off for a long stretch so the block's
  // internal buffering fills and in_stall has to rise. In the calm last part
  // of the run it never stalls.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] any_word();
    return {$urandom, $urandom};
  endfunction

  // A byte that the block will store in a reply rather than echo.
  function automatic logic [7:0] byte_not_init();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == init_now);
    return b;
  endfunction

  // Leading reply byte that signals a positive acknowledgement.
  function automatic logic [7:0] lead_byte_ok();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == init_now || b == err_now);
    return b;
  endfunction

  // A message that can be echoed back, so none of its bytes is the init
  // character. Bytes lean toward 00 and FF to reach the extremes.
  function automatic logic [63:0] echoable_msg();
    logic [63:0] m;
    logic [7:0]  b;
    int          pick;
    for (int i = 0; i < 8; i++) begin
      do begin
        pick = $urandom_range(0, 9);
        b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end while (b == init_now);
      m[8*i +: 8] = b;
    end
    return m;
  endfunction

  // Offers one word and returns at the edge where it is taken. The sender
  // sometimes idles first, so gaps land on every phase of the block's work.
  // The local copy of link state and reply position follows what the block
  // does with received bytes.
  task automatic offer_word(input logic [1:0] m, input logic [7:0] rx,
                            input logic [63:0] msg);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= rx;
    message  <= msg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (m == MODE_RX) begin
      if (!link_seen) begin
        if (rx == init_now) link_seen = 1'b1;
      end else if (rx != init_now) begin
        reply_fill = (reply_fill + 1) % REPLY_LEN;
      end
    end
  endtask

  // Sends a full reply carrying the given body. Any partial reply left by
  // stray bytes is completed first so the new one lines up. Options: lead
  // with the error character, corrupt one body byte, or slip an init
  // character into the middle (it must be echoed without breaking the reply).
  task automatic send_reply(input logic [63:0] body, input bit err_lead,
                            input bit corrupt, input bit splice);
    int         bad_pos;
    int         init_pos;
    logic [7:0] b;
    logic [7:0] c;
    bad_pos  = corrupt ? $urandom_range(0, 7) : -1;
    init_pos = splice ? $urandom_range(0, 7) : -1;
    while (reply_fill != 0) offer_word(MODE_RX, byte_not_init(), any_word());
    offer_word(MODE_RX, err_lead ? err_now : lead_byte_ok(), any_word());
    for (int i = 0; i < 8; i++) begin
      if (i == init_pos) offer_word(MODE_RX, init_now, any_word());
      b = body[8*i +: 8];
      if (i == bad_pos) begin
        do c = 8'($urandom_range(0, 255)); while (c == b || c == init_now);
        b = c;
      end
      offer_word(MODE_RX, b, any_word());
    end
  endtask

  // Acknowledges the head message properly and forgets it.
  task automatic ack_head(input bit splice);
    send_reply(held_msgs[0], 1'b0, 1'b0, splice);
    void'(held_msgs.pop_front());
    good_replies++;
  endtask

  task automatic enqueue_one(input logic [63:0] msg);
    // Past eight messages the block must drop the word, so nothing is
    // remembered for it.
    if (held_msgs.size() < QUEUE_SLOTS) held_msgs.push_back(msg);
    offer_word(MODE_ENQ, 8'($urandom_range(0, 255)), msg);
  endtask

  // Lowers valid and waits until every result word has been taken, so the
  // block is idle and the registers may be rewritten.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_chars(input logic [7:0] init_c, input logic [7:0] err_c);
    cfg_write <= 1'b1;
    cfg_index <= CFG_INIT_CHAR;
    cfg_data  <= init_c;
    @(posedge clk);
    cfg_index <= CFG_ERROR_CHAR;
    cfg_data  <= err_c;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    init_now = init_c;
    err_now  = err_c;
  endtask

  // One random phase: a burst that overfills the message queue, then a mix
  // dominated by well-formed enqueue, tick and reply sequences, with broken
  // replies and stray words in between. Ends by acknowledging everything
  // still queued so that the next register setting starts clean.
  task automatic run_phase(input int goal);
    int stop_at;
    int pick;
    stop_at = words_sent + goal;
    enqueue_one((init_now != 8'h00) ? 64'd0 : ~64'd0);
    repeat (QUEUE_SLOTS) enqueue_one(held_msgs.size() < QUEUE_SLOTS ? echoable_msg()
                                                                    : any_word());
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        enqueue_one(held_msgs.size() < QUEUE_SLOTS ? echoable_msg() : any_word());
      end else if (pick < 40) begin
        offer_word(MODE_TICK, 8'($urandom_range(0, 255)), any_word());
      end else if (pick < 68) begin
        if (held_msgs.size() != 0) begin
          ack_head($urandom_range(0, 4) == 0);
        end else begin
          // Reply arriving while nothing is queued.
          send_reply(echoable_msg(), 1'b0, 1'b0, 1'b0);
          bad_replies++;
        end
      end else if (pick < 80) begin
        if (err_now != init_now && $urandom_range(0, 1) == 0) begin
          send_reply(held_msgs.size() != 0 ? held_msgs[0] : echoable_msg(),
                     1'b1, 1'b0, 1'b0);
        end else begin
          send_reply(held_msgs.size() != 0 ? held_msgs[0] : echoable_msg(),
                     1'b0, 1'b1, 1'b0);
        end
        bad_replies++;
      end else if (pick < 87) begin
        offer_word(MODE_RX, byte_not_init(), any_word());
      end else if (pick < 93) begin
        offer_word(MODE_RX, init_now, any_word());
      end else begin
        offer_word(MODE_UNUSED, 8'($urandom_range(0, 255)), any_word());
      end
    end
    while (held_msgs.size() != 0) ack_head(1'b0);
  endtask

  initial begin
    in_valid     = 1'b0;
    mode         = MODE_TICK;
    rx_byte      = 8'h00;
    message      = 64'd0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_INIT_CHAR;
    cfg_data     = 8'h00;
    init_now     = 8'h00;
    err_now      = 8'h00;
    link_seen    = 1'b0;
    reply_fill   = 0;
    calm         = 1'b0;
    hold_go      = 1'b0;
    words_sent   = 0;
    good_replies = 0;
    bad_replies  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with both characters at their reset value of zero.
    // Before the link is up, stray bytes are dropped, ticks send nothing,
    // the unused mode is ignored and enqueues are still accepted.
    offer_word(MODE_RX, 8'hA5, 64'd0);
    offer_word(MODE_RX, 8'hFF, ~64'd0);
    offer_word(MODE_TICK, 8'h00, 64'd0);
    offer_word(MODE_UNUSED, 8'hFF, ~64'd0);
    enqueue_one(64'h8877_6655_4433_2211);
    enqueue_one(~64'd0);
    // The init character brings the link up and is echoed; the first tick
    // then sends the head and a second tick finds it still unacknowledged.
    offer_word(MODE_RX, init_now, 64'd0);
    offer_word(MODE_TICK, 8'hFF, ~64'd0);
    offer_word(MODE_TICK, 8'h00, 64'd0);
    // A good reply with an init echo spliced in acknowledges the head and
    // sends the all-ones message.
    ack_head(1'b1);

    run_phase(PHASE_WORDS);
    settle();

    // Second setting: the long output hold-off happens while the queue
    // burst is being offered.
    load_chars(8'h7E, 8'h15);
    hold_go = 1'b1;
    run_phase(PHASE_WORDS);
    settle();

    load_chars(8'hFF, 8'h00);
    run_phase(PHASE_WORDS);
    settle();

    load_chars(8'h00, 8'hFF);
    run_phase(PHASE_WORDS);
    settle();

    // Last part: random characters and no idling on either side.
    calm = 1'b1;
    load_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(PHASE_WORDS);
    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d words under five character settings, including 00 and FF.",
             words_sent);
    $display("Replies: %0d acknowledging, %0d broken or unmatched; one %0d-cycle hold-off.",
             good_replies, bad_replies, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/saw_pkg.sv
rtl/saw_front.sv
rtl/saw_fifo.sv
rtl/saw_back.sv
rtl/stop_and_wait_echo_ack_sender_core.sv
bench/saw_result_checker.sv
bench/tb_stop_and_wait_echo_ack_sender_core.sv
